@@ rtl/ostp_pkg.sv @@
// Package: constants, payload structs and sequencer states for the timer slot pool.
`timescale 1ns / 1ps
package ostp_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [31:0] DEFAULT_DURATION = 32'd10000;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] ST_STARTED = 2'd0;
	localparam logic [1:0] ST_NO_SLOT = 2'd1;
	localparam logic [1:0] ST_EXPIRED = 2'd2;

	typedef struct packed {
		logic        command;
		logic [31:0] now_ms;
		logic [15:0] target_id;
		logic [1:0]  timer_kind;
	} ostp_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  slot_index;
		logic [15:0] expired_target;
		logic [1:0]  expired_kind;
		logic        last;
	} ostp_rsp_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_FLUSH
	} ostp_state_t;

endpackage

@@ rtl/one_shot_timer_pool.sv @@
// Top level: one-shot timer slot pool, scanning one slot per cycle unless the output stalls.
// Start: accepted in idle, then slots are scanned in index order up to the lowest free one,
//   then a flush state registers the result to the output; NO_SLOT if none is free.
// Tick: all SLOT_COUNT slots are scanned in index order, then a flush state; a new request
//   is accepted only back in idle. A single 32-bit adder serves both commands.
// Reset: all slots free, duration_ms = 10000, no result pending.
`timescale 1ns / 1ps
module one_shot_timer_pool (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ostp_pkg::ostp_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ostp_pkg::ostp_rsp_t rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);
	import ostp_pkg::*;

	ostp_state_t state_q, state_d;

	logic [31:0] duration_q;
	logic        active_q [SLOT_COUNT];
	logic [31:0] deadline_q [SLOT_COUNT];
	logic [15:0] target_arr_q [SLOT_COUNT];
	logic [1:0]  kind_arr_q [SLOT_COUNT];

	logic        cmd_q;
	logic [31:0] now_q;
	logic [15:0] target_q;
	logic [1:0]  kind_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;

	ostp_rsp_t pend_q, out_q;
	logic      pend_valid_q, out_valid_q;

	logic [31:0] add_a, add_b, sum;
	logic        add_cin;
	logic        last_idx, can_push;
	logic        hit, stall, advance, push, load_pend, clear_pend, claim, release_slot;
	ostp_rsp_t   push_data, new_pend;

	assign req_ready = (state_q == SEQ_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	assign last_idx = (idx_q == IDX_W'(SLOT_COUNT - 1));
	assign can_push = !out_valid_q || rsp_ready;

	// shared adder: now + duration on start, deadline - now on tick
	always_comb begin
		add_a = (cmd_q == CMD_TICK) ? deadline_q[idx_q] : now_q;
		add_b = (cmd_q == CMD_TICK) ? ~now_q : duration_q;
		add_cin = (cmd_q == CMD_TICK);
		sum = add_a + add_b + 32'(add_cin);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: begin
				if (req_valid) state_d = SEQ_SCAN;
			end
			SEQ_SCAN: begin
				if (!stall && ((cmd_q == CMD_START && hit) || last_idx)) state_d = SEQ_FLUSH;
			end
			SEQ_FLUSH: begin
				if (!pend_valid_q || can_push) state_d = SEQ_IDLE;
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_comb begin
		hit = 1'b0;
		stall = 1'b0;
		advance = 1'b0;
		push = 1'b0;
		push_data = pend_q;
		load_pend = 1'b0;
		clear_pend = 1'b0;
		claim = 1'b0;
		release_slot = 1'b0;
		new_pend = '0;
		case (state_q)
			SEQ_SCAN: begin
				if (cmd_q == CMD_TICK) begin
					hit = active_q[idx_q] && sum[31] && (cnt_q < CNT_W'(MAX_RESULTS));
				end else begin
					hit = !active_q[idx_q];
				end
				stall = hit && pend_valid_q && !can_push;
				if (!stall) begin
					advance = 1'b1;
					if (hit) begin
						push = pend_valid_q;
						push_data.last = 1'b0;
						load_pend = 1'b1;
						new_pend.slot_index = 3'(idx_q);
						if (cmd_q == CMD_TICK) begin
							new_pend.status = ST_EXPIRED;
							new_pend.expired_target = target_arr_q[idx_q];
							new_pend.expired_kind = kind_arr_q[idx_q];
							release_slot = 1'b1;
						end else begin
							new_pend.status = ST_STARTED;
							new_pend.expired_target = target_q;
							new_pend.expired_kind = kind_q;
							claim = 1'b1;
						end
					end else if (cmd_q == CMD_START && last_idx) begin
						load_pend = 1'b1;
						new_pend.status = ST_NO_SLOT;
					end
				end
			end
			SEQ_FLUSH: begin
				if (pend_valid_q && can_push) begin
					push = 1'b1;
					push_data.last = 1'b1;
					clear_pend = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			duration_q <= DEFAULT_DURATION;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) active_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) duration_q <= cfg_data;
			if (state_q == SEQ_IDLE && req_valid) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (advance && !(cmd_q == CMD_START && hit) && !last_idx) begin
				idx_q <= idx_q + 1'b1;
			end
			if (release_slot) cnt_q <= cnt_q + 1'b1;
			if (claim) active_q[idx_q] <= 1'b1;
			if (release_slot) active_q[idx_q] <= 1'b0;
			if (load_pend) pend_valid_q <= 1'b1;
			else if (clear_pend) pend_valid_q <= 1'b0;
			if (push) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_IDLE && req_valid) begin
			cmd_q <= req.command;
			now_q <= req.now_ms;
			target_q <= req.target_id;
			kind_q <= req.timer_kind;
		end
		if (claim) begin
			deadline_q[idx_q] <= sum;
			target_arr_q[idx_q] <= target_q;
			kind_arr_q[idx_q] <= kind_q;
		end
		if (load_pend) pend_q <= new_pend;
		if (push) out_q <= push_data;
	end

endmodule
